// File: rtl/cvb_pkg.sv
// shared types and codes for the compacting value bag
// no dependencies; used by cvb_ctrl and compacting_value_bag
package cvb_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef enum logic [1:0] {
        KIND_ADD      = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_CONTAINS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_MISSING = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic    found;
        t_status status;
    } t_result;

endpackage

// File: rtl/compacting_value_bag.sv
// from the accepting edge: add or unused kind passes the execute state, contains searches
// with one search read per cycle, remove searches and then shifts with one shift read and
// write per cycle on the two-port store; each result then goes to the output register
// one item at a time; the next item is taken in the cycle after the result enters the
// output register, and a result waits there while m_axis_tready is low
// reset clears the count and control state; the entry store is not cleared
module compacting_value_bag #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // value[31:0]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // found[0], status[2:1], count[7:3]
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                        res_valid;
    logic                        res_free;
    cvb_pkg::t_result            res;
    logic [CW-1:0]               count;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [cvb_pkg::VALUE_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [cvb_pkg::VALUE_W-1:0] mem_rdata;
    logic                        r_out_valid;
    logic [7:0]                  r_out_data;

    cvb_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .o_res_valid (res_valid),
        .i_res_free  (res_free),
        .o_res       (res),
        .o_count     (count),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    cvb_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (cvb_pkg::VALUE_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign res_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_free && res_valid) begin
            r_out_data <= {5'(count), res.status, res.found};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: rtl/cvb_mem.sv
// entry store: one write port, one registered read port
// no dependencies; instantiated by compacting_value_bag
module cvb_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/cvb_ctrl.sv
// operation sequencer: append, pipelined search and pipelined compaction shift
// depends on cvb_pkg; drives the ports of cvb_mem
module cvb_ctrl #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned AW       = 4,
    parameter int unsigned CW       = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_kind,
    input  logic [cvb_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_res_valid,
    input  logic                         i_res_free,
    output cvb_pkg::t_result             o_res,
    output logic [CW-1:0]                o_count,
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output logic [cvb_pkg::VALUE_W-1:0]  o_mem_wdata,
    output logic                         o_mem_re,
    output logic [AW-1:0]                o_mem_raddr,
    input  logic [cvb_pkg::VALUE_W-1:0]  i_mem_rdata
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    cvb_pkg::t_state             r_state, n_state;
    logic [1:0]                  r_kind, n_kind;
    logic [cvb_pkg::VALUE_W-1:0] r_value, n_value;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_idx, n_idx;
    logic                        r_pend, n_pend;
    logic [AW-1:0]               r_pend_addr, n_pend_addr;
    cvb_pkg::t_result            r_res, n_res;
    logic                        more;
    logic                        hit;

    assign more = (r_idx < r_count);
    assign hit  = r_pend && (i_mem_rdata == r_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cvb_pkg::ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_value     <= n_value;
        r_idx       <= n_idx;
        r_pend_addr <= n_pend_addr;
        r_res       <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_value     = r_value;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_res       = r_res;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_count[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx[AW-1:0];
        unique case (r_state)
            cvb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_value = i_value;
                    n_idx   = '0;
                    if (i_kind == cvb_pkg::KIND_REMOVE || i_kind == cvb_pkg::KIND_CONTAINS) begin
                        n_state = cvb_pkg::ST_SCAN;
                    end else begin
                        n_state = cvb_pkg::ST_EXEC;
                    end
                end
            end
            cvb_pkg::ST_EXEC: begin
                n_res.found  = 1'b0;
                n_res.status = cvb_pkg::STATUS_DONE;
                if (r_kind == cvb_pkg::KIND_ADD) begin
                    if (r_count >= CAP_C) begin
                        n_res.status = cvb_pkg::STATUS_FULL;
                    end else begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = r_value;
                        n_count     = r_count + 1'b1;
                    end
                end
                n_state = cvb_pkg::ST_DONE;
            end
            cvb_pkg::ST_SCAN: begin
                if (hit) begin
                    n_res.found  = 1'b1;
                    n_res.status = cvb_pkg::STATUS_DONE;
                    if (r_kind == cvb_pkg::KIND_REMOVE) begin
                        n_idx   = CW'(r_pend_addr) + 1'b1;
                        n_state = cvb_pkg::ST_SHIFT;
                    end else begin
                        n_state = cvb_pkg::ST_DONE;
                    end
                end else if (more) begin
                    o_mem_re    = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx[AW-1:0];
                    n_idx       = r_idx + 1'b1;
                end else if (!r_pend) begin
                    n_res.found = 1'b0;
                    if (r_kind == cvb_pkg::KIND_REMOVE) begin
                        n_res.status = cvb_pkg::STATUS_MISSING;
                    end else begin
                        n_res.status = cvb_pkg::STATUS_DONE;
                    end
                    n_state = cvb_pkg::ST_DONE;
                end
            end
            cvb_pkg::ST_SHIFT: begin
                // entry read last cycle moves down one place
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pend_addr - 1'b1;
                end
                if (more) begin
                    o_mem_re    = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx[AW-1:0];
                    n_idx       = r_idx + 1'b1;
                end else if (!r_pend) begin
                    n_count = r_count - 1'b1;
                    n_state = cvb_pkg::ST_DONE;
                end
            end
            cvb_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_free) begin
                    n_state = cvb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cvb_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res   = r_res;
    assign o_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_re |-> (CW'(o_mem_raddr) < r_count))
        else $error("read of an entry beyond the held count");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (CW'(o_mem_waddr) < CAP_C))
        else $error("write beyond capacity");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
        ($past(r_state) == cvb_pkg::ST_EXEC || $past(r_state) == cvb_pkg::ST_SHIFT))
        else $error("count changed outside append or shift");

    a_full_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_res.status == cvb_pkg::STATUS_FULL) |->
        (r_kind == cvb_pkg::KIND_ADD && r_count == CAP_C))
        else $error("full status without an add to a full bag");

endmodule
